/* hw/rtl/ogs_pkg.sv */
// Shared constants and types for the orbit gravity step block.
package ogs_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_PULL     = 3'd2;
    localparam logic [2:0] REG_CONTACT  = 3'd3;
    localparam logic [2:0] REG_BOUNCE   = 3'd4;

    // Operations of the shared divide/root unit
    localparam logic [1:0] OP_SQRT = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;

    // Request to the shared unit
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [65:0] num;
        logic [63:0] den;
    } t_unit_req;

    // Response from the shared unit
    typedef struct packed {
        logic        done;
        logic [65:0] res;
    } t_unit_rsp;

endpackage

/* hw/rtl/orbit_gravity_step_core.sv */
// Top level of the orbit gravity step block: registers, sequencer and state.
// A place item passes through the output state before its result shows. A tick
// runs two square roots (before and after the move) and four divisions on the
// shared unit, plus two more divisions for the bounce when the moved body is
// within the contact distance, and single sequencer steps for the square setup,
// the multiplies, the move and the output. The block takes no item until the
// result of the last one is taken, so the next item enters in the cycle after
// that result is taken at the earliest.
module orbit_gravity_step_core
    import ogs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic signed [31:0] i_place_x,
    input  logic signed [31:0] i_place_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_body_x,
    output logic signed [31:0] o_body_y,
    output logic        o_bounced,
    output logic        o_saturated
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_DIVT  = 4'd3;
    localparam logic [3:0] S_DIVU  = 4'd4;
    localparam logic [3:0] S_MULX  = 4'd5;
    localparam logic [3:0] S_DIVX  = 4'd6;
    localparam logic [3:0] S_MULY  = 4'd7;
    localparam logic [3:0] S_DIVY  = 4'd8;
    localparam logic [3:0] S_MOVE  = 4'd9;
    localparam logic [3:0] S_SQ2   = 4'd10;
    localparam logic [3:0] S_ROOT2 = 4'd11;
    localparam logic [3:0] S_BNCE  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_BNCEY = 4'd14;

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
    localparam logic signed [33:0] SMAX = 34'sd2147483647;
    localparam logic signed [33:0] SMIN = -34'sd2147483648;

    logic signed [31:0] r_cx, r_cy;
    logic [30:0] r_pull, r_contact;
    logic [7:0]  r_bdiv;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic [3:0]  r_st;
    logic        r_phase;
    logic signed [32:0] r_dx, r_dy;
    logic [65:0] r_acc;
    logic [63:0] r_dist;
    logic [65:0] r_u;
    logic        r_sat, r_hit, r_out_v;
    t_unit_req   w_req;
    t_unit_rsp   w_rsp;

    logic w_cfg_wr, w_in_acc;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_in_acc = i_valid & ~o_stall;
    assign o_stall  = (r_st != S_IDLE) | r_out_v;

    // Configuration write and read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0;
            r_pull <= 31'(100 << FRAC_BITS);
            r_contact <= 31'(60 << FRAC_BITS);
            r_bdiv <= 8'd70;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_CENTER_X: r_cx <= pwdata;
                REG_CENTER_Y: r_cy <= pwdata;
                REG_PULL:     r_pull <= pwdata[30:0];
                REG_CONTACT:  r_contact <= pwdata[30:0];
                REG_BOUNCE:   r_bdiv <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_PULL:     prdata = {1'b0, r_pull};
            REG_CONTACT:  prdata = {1'b0, r_contact};
            REG_BOUNCE:   prdata = {24'd0, r_bdiv};
            default:      prdata = '0;
        endcase
    end

    ogs_unit u_unit (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // Shared-unit helpers
    logic [32:0] w_adx, w_ady;
    logic [65:0] w_sq;
    logic [63:0] w_root;
    logic signed [33:0] w_sum_vx, w_sum_vy, w_sum_px, w_sum_py;
    logic signed [32:0] w_amag;
    logic signed [33:0] w_acc_s, w_bq, w_bsum;
    logic signed [31:0] w_bv;
    logic [32:0] w_avx, w_avy;
    logic [8:0] w_div;
    logic       w_hit;
    assign w_adx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ady = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign w_sq  = 66'(w_adx) * 66'(w_adx) + 66'(w_ady) * 66'(w_ady);
    assign w_root = 64'(w_rsp.res);
    assign w_hit = (w_root <= 64'(r_contact));
    assign w_div = (r_bdiv == 8'd0) ? 9'd1 : {1'b0, r_bdiv};
    assign w_amag = 33'(w_rsp.res[31:0]);
    assign w_acc_s = r_phase ? (r_dy[32] ? -34'(w_amag) : 34'(w_amag))
                             : (r_dx[32] ? -34'(w_amag) : 34'(w_amag));
    assign w_sum_vx = 34'(r_vx) + w_acc_s;
    assign w_sum_vy = 34'(r_vy) + w_acc_s;
    assign w_sum_px = 34'(r_px) + 34'(r_vx);
    assign w_sum_py = 34'(r_py) + 34'(r_vy);

    // Bounce: divide the velocity magnitude on the shared unit, restore the sign, and add it to the negated velocity
    assign w_avx = r_vx[31] ? 33'(-34'(r_vx)) : 33'(r_vx);
    assign w_avy = r_vy[31] ? 33'(-34'(r_vy)) : 33'(r_vy);
    assign w_bv  = (r_st == S_BNCEY) ? r_vy : r_vx;
    assign w_bq  = w_bv[31] ? -$signed({2'b00, w_rsp.res[31:0]})
                            : $signed({2'b00, w_rsp.res[31:0]});
    assign w_bsum = -34'(w_bv) + w_bq;

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > SMAX) return 32'sh7FFFFFFF;
        if (v < SMIN) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic ovf(input logic signed [33:0] v);
        return (v > SMAX) || (v < SMIN);
    endfunction

    // Sequencer
    always_comb begin
        w_req = '0;
        unique case (r_st)
            S_SQ, S_SQ2: begin
                w_req.start = 1'b1; w_req.op = OP_SQRT; w_req.num = w_sq;
            end
            S_ROOT: if (w_rsp.done) begin
                w_req.start = 1'b1; w_req.op = OP_DIV;
                w_req.num = 66'(r_pull) << FRAC_BITS;
                w_req.den = (w_root < ONE) ? ONE : w_root;
            end
            S_DIVT: if (w_rsp.done) begin
                w_req.start = 1'b1; w_req.op = OP_DIV;
                w_req.num = w_rsp.res << FRAC_BITS; w_req.den = r_dist;
            end
            S_MULX, S_MULY: begin
                w_req.start = 1'b1; w_req.op = OP_DIV;
                w_req.num = r_acc; w_req.den = r_dist;
            end
            S_ROOT2: if (w_rsp.done && w_hit) begin
                w_req.start = 1'b1; w_req.op = OP_DIV;
                w_req.num = 66'(w_avx); w_req.den = 64'(w_div);
            end
            S_BNCE: if (w_rsp.done) begin
                w_req.start = 1'b1; w_req.op = OP_DIV;
                w_req.num = 66'(w_avy); w_req.den = 64'(w_div);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_out_v <= 1'b0;
            r_px <= '0; r_py <= '0;
            r_vx <= 32'(1) <<< (FRAC_BITS - 1); r_vy <= '0;
            r_sat <= 1'b0; r_hit <= 1'b0; r_phase <= 1'b0;
        end else begin
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_in_acc) begin
                    r_sat <= 1'b0; r_hit <= 1'b0;
                    if (i_kind) begin
                        r_px <= i_place_x; r_py <= i_place_y; r_st <= S_OUT;
                    end else begin
                        r_dx <= 33'(r_cx) - 33'(r_px);
                        r_dy <= 33'(r_cy) - 33'(r_py);
                        r_st <= S_SQ;
                    end
                end
                S_SQ:   r_st <= S_ROOT;
                S_ROOT: if (w_rsp.done) begin
                    r_dist <= (w_root < ONE) ? ONE : w_root;
                    r_st <= S_DIVT;
                end
                S_DIVT: if (w_rsp.done) r_st <= S_DIVU;
                S_DIVU: if (w_rsp.done) begin
                    r_u <= w_rsp.res;
                    r_acc <= 66'(64'(w_rsp.res[31:0]) * 64'(w_adx));
                    r_st <= S_MULX;
                end
                S_MULX: begin r_phase <= 1'b0; r_st <= S_DIVX; end
                S_DIVX: if (w_rsp.done) begin
                    r_vx <= sat(w_sum_vx);
                    if (ovf(w_sum_vx)) r_sat <= 1'b1;
                    r_acc <= 66'(64'(r_u[31:0]) * 64'(w_ady));
                    r_st <= S_MULY;
                end
                S_MULY: begin r_phase <= 1'b1; r_st <= S_DIVY; end
                S_DIVY: if (w_rsp.done) begin
                    r_vy <= sat(w_sum_vy);
                    if (ovf(w_sum_vy)) r_sat <= 1'b1;
                    r_st <= S_MOVE;
                end
                S_MOVE: begin
                    r_px <= sat(w_sum_px); r_py <= sat(w_sum_py);
                    if (ovf(w_sum_px) || ovf(w_sum_py)) r_sat <= 1'b1;
                    r_dx <= 33'(r_cx) - 33'(sat(w_sum_px));
                    r_dy <= 33'(r_cy) - 33'(sat(w_sum_py));
                    r_st <= S_SQ2;
                end
                S_SQ2:  r_st <= S_ROOT2;
                S_ROOT2: if (w_rsp.done) begin
                    if (w_hit) begin
                        r_hit <= 1'b1;
                        r_st <= S_BNCE;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_BNCE: if (w_rsp.done) begin
                    r_vx <= sat(w_bsum);
                    if (ovf(w_bsum)) r_sat <= 1'b1;
                    r_st <= S_BNCEY;
                end
                S_BNCEY: if (w_rsp.done) begin
                    r_vy <= sat(w_bsum);
                    if (ovf(w_bsum)) r_sat <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: begin r_out_v <= 1'b1; r_st <= S_IDLE; end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_v;
    assign o_body_x    = r_px;
    assign o_body_y    = r_py;
    assign o_bounced   = r_hit;
    assign o_saturated = r_sat;

    // No item accepted while a tick is in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !w_in_acc) else $error("item taken while busy");
    // A bounce always reports a hit
    a_bounce_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_BNCE) |-> r_hit) else $error("bounce without hit flag");
    // Result shows only after the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_st == S_OUT)) else $error("result without step");

endmodule

/* hw/rtl/ogs_unit.sv */
// Shared iterative unit: restoring division and bitwise integer square root.
module ogs_unit
    import ogs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    localparam int unsigned NB = 66;
    localparam int unsigned NB_HALF = NB / 2;

    logic [NB-1:0] r_num, n_num;
    logic [NB-1:0] r_rem, n_rem;
    logic [NB-1:0] r_res, n_res;
    logic [63:0]   r_den;
    logic          r_op;
    logic [6:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [NB+1:0] w_trial;
    logic [NB+1:0] w_rem2;
    logic [NB+1:0] w_sub;

    // One quotient bit, or one root bit (two radicand bits), per cycle
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_res  = r_res;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_rem2 = '0;
        w_sub  = '0;
        w_trial = '0;
        if (r_op == OP_DIV[0]) begin
            w_rem2 = {1'b0, r_rem, r_num[NB-1]};
            w_sub  = {4'b0, r_den};
        end else begin
            w_rem2 = {r_rem, r_num[NB-1 -: 2]};
            w_sub  = {r_res, 2'b01};
        end
        w_trial = w_rem2 - w_sub;
        if (r_busy) begin
            if (!w_trial[NB+1]) begin
                n_rem = w_trial[NB-1:0];
                n_res = {r_res[NB-2:0], 1'b1};
            end else begin
                n_rem = w_rem2[NB-1:0];
                n_res = {r_res[NB-2:0], 1'b0};
            end
            n_num = (r_op == OP_DIV[0]) ? {r_num[NB-2:0], 1'b0} : {r_num[NB-3:0], 2'b00};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Load a new operation or advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= (i_req.op == OP_DIV) ? 7'(NB) : 7'(NB_HALF);
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_op  <= (i_req.op == OP_DIV);
            r_rem <= '0;
            r_res <= '0;
        end else begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the orbit gravity step core.
`timescale 1ns / 1ps

module testbench;
    import ogs_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 1600;
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] px;
        logic [31:0] py;
    } t_body_cmd;

    typedef struct packed {
        logic [31:0] bx;
        logic [31:0] by;
        logic        bounced;
        logic        saturated;
    } t_body_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = 1'b0;
    logic signed [31:0] i_place_x = '0, i_place_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_body_x, o_body_y;
    logic o_bounced, o_saturated;

    orbit_gravity_step_core u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and body state
    longint cfg_cx, cfg_cy, cfg_pull, cfg_contact, cfg_bounce;
    longint body_px, body_py, body_vx, body_vy;

    t_body_cmd   cmd_queue[$];
    t_body_state expected_states[$];
    int  fail_count = 0;
    int  items_sent = 0, results_seen = 0, bounce_seen = 0, sat_seen = 0;
    int  idle_cycles = 0;
    bit  feed_done = 0;

    function automatic longint clamp32(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact floor square root of dx^2 + dy^2, on 66 bits
    function automatic longint unsigned body_distance(longint dx, longint dy);
        logic [65:0] m, res, bitv;
        logic [63:0] ux, uy;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        m = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
        res = '0;
        bitv = 66'd1 << 64;
        while (bitv > m) bitv >>= 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[63:0];
    endfunction

    function automatic longint pull_accel(longint unsigned u, longint d,
                                          longint unsigned radius);
        logic [127:0] prod;
        longint unsigned ud;
        longint mag;
        ud = d < 0 ? -d : d;
        prod = 128'(u) * 128'(ud);
        mag = longint'(prod / radius);
        return d < 0 ? -mag : mag;
    endfunction

    function automatic longint bounce_vel(longint v, ref bit flag);
        longint dv;
        dv = cfg_bounce == 0 ? 1 : cfg_bounce;
        return clamp32(-v + v / dv, flag);
    endfunction

    // Advance the predicted body by one item
    function automatic t_body_state predict_body(t_body_cmd c);
        t_body_state r;
        bit sat, hit;
        longint dx, dy;
        longint unsigned radius, t, u;
        sat = 0;
        hit = 0;
        if (c.kind == KIND_PLACE) begin
            body_px = longint'(signed'(c.px));
            body_py = longint'(signed'(c.py));
        end else begin
            dx = cfg_cx - body_px;
            dy = cfg_cy - body_py;
            radius = body_distance(dx, dy);
            if (radius < (64'd1 << FRAC)) radius = 64'd1 << FRAC;
            t = (cfg_pull << FRAC) / radius;
            u = (t << FRAC) / radius;
            body_vx = clamp32(body_vx + pull_accel(u, dx, radius), sat);
            body_vy = clamp32(body_vy + pull_accel(u, dy, radius), sat);
            body_px = clamp32(body_px + body_vx, sat);
            body_py = clamp32(body_py + body_vy, sat);
            if (body_distance(cfg_cx - body_px, cfg_cy - body_py) <= cfg_contact) begin
                hit = 1;
                body_vy = bounce_vel(body_vy, sat);
                body_vx = bounce_vel(body_vx, sat);
            end
        end
        r.bx = body_px[31:0];
        r.by = body_py[31:0];
        r.bounced = hit;
        r.saturated = sat;
        return r;
    endfunction

    // Driver: bursts of items with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (i_valid) items_sent <= items_sent + 1;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    t_body_cmd c;
                    c = cmd_queue.pop_front();
                    expected_states.push_back(predict_body(c));
                    i_valid <= 1'b1;
                    i_kind <= c.kind;
                    i_place_x <= c.px;
                    i_place_y <= c.py;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: long quiet stretches and stall runs
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 256;
        if (stall_phase < 96) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 2) == 0);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        int errs;
        t_body_state e;
        if (i_rst_n && o_valid && !i_stall) begin
            errs = 0;
            if (expected_states.size() == 0) begin
                $error("result with no expectation: x=%h y=%h", o_body_x, o_body_y);
                errs = errs + 1;
            end else begin
                e = expected_states.pop_front();
                if (o_body_x !== e.bx) begin
                    $error("body_x expected %h actual %h", e.bx, o_body_x);
                    errs = errs + 1;
                end
                if (o_body_y !== e.by) begin
                    $error("body_y expected %h actual %h", e.by, o_body_y);
                    errs = errs + 1;
                end
                if (o_bounced !== e.bounced) begin
                    $error("bounced expected %b actual %b", e.bounced, o_bounced);
                    errs = errs + 1;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated expected %b actual %b", e.saturated, o_saturated);
                    errs = errs + 1;
                end
                bounce_seen <= bounce_seen + e.bounced;
                sat_seen <= sat_seen + e.saturated;
            end
            fail_count <= fail_count + errs;
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog: end the run when no item is accepted and no result is taken for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || feed_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d items", results_seen);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CENTER_X: cfg_cx = longint'(signed'(value));
            REG_CENTER_Y: cfg_cy = longint'(signed'(value));
            REG_PULL:     cfg_pull = value[30:0];
            REG_CONTACT:  cfg_contact = value[30:0];
            REG_BOUNCE:   cfg_bounce = value[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || expected_states.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_cmd(logic kind, logic [31:0] px, logic [31:0] py);
        t_body_cmd c;
        c.kind = kind;
        c.px = px;
        c.py = py;
        cmd_queue.push_back(c);
    endtask

    // An orbit: place near the center, then a run of ticks
    task automatic push_orbit(int ticks, int span);
        push_cmd(KIND_PLACE, 32'(cfg_cx + $signed($urandom_range(0, 2 * span)) - span),
                 32'(cfg_cy + $signed($urandom_range(0, 2 * span)) - span));
        repeat (ticks) push_cmd(KIND_TICK, $urandom, $urandom);
    endtask

    task automatic random_config(int mode);
        write_reg(REG_CENTER_X, mode == 0 ? $urandom : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        write_reg(REG_CENTER_Y, mode == 0 ? $urandom : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        write_reg(REG_PULL, mode == 1 ? 32'h7FFF_FFFF : $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20));
        write_reg(REG_CONTACT, $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(8, 30));
        write_reg(REG_BOUNCE, mode == 2 ? 0 : $urandom_range(1, 255));
    endtask

    initial begin
        int phase;
        cfg_cx = 0; cfg_cy = 0;
        cfg_pull = 100 << FRAC; cfg_contact = 60 << FRAC; cfg_bounce = 70;
        body_px = 0; body_py = 0; body_vx = 1 << (FRAC - 1); body_vy = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, extremes, overflow and contact
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(KIND_PLACE, 32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_PLACE, 32'h8000_0000, 32'h7FFF_FFFF);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_PLACE, 32'h0000_8000, 32'hFFFF_8000);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_PLACE, 32'h0064_0000, 32'h0);
        repeat (4) push_cmd(KIND_TICK, 32'h0, 32'h0);
        wait_idle();

        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_PULL, 32'h7FFF_FFFF);
        write_reg(REG_CONTACT, 32'h7FFF_FFFF);
        write_reg(REG_BOUNCE, 32'h0);
        push_cmd(KIND_PLACE, 32'h8000_0000, 32'h7FFF_FFFF);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_PLACE, 32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        wait_idle();

        write_reg(REG_PULL, 32'h0);
        write_reg(REG_CONTACT, 32'h0);
        write_reg(REG_BOUNCE, 32'd255);
        write_reg(REG_CENTER_X, 32'h0);
        write_reg(REG_CENTER_Y, 32'h0);
        push_cmd(KIND_PLACE, 32'h0, 32'h0);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        push_cmd(KIND_TICK, 32'h0, 32'h0);
        wait_idle();

        // Random phases: mostly orbits under varied settings, some noise
        for (phase = 0; phase < 16; phase++) begin
            random_config(phase % 4);
            while (cmd_queue.size() < RANDOM_ITEMS / 16) begin
                if ($urandom_range(0, 4) != 0)
                    push_orbit($urandom_range(2, 15), 1 << $urandom_range(16, 30));
                else
                    push_cmd($urandom_range(0, 1), $urandom, $urandom);
            end
            wait_idle();
        end

        feed_done = 1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items, %0d results, %0d bounces, %0d saturations",
                 items_sent, results_seen, bounce_seen, sat_seen);
        if (fail_count == 0 && expected_states.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ogs_pkg.sv
hw/rtl/ogs_unit.sv
hw/rtl/orbit_gravity_step_core.sv
dv/testbench.sv
